[rtl/kf2_pkg.sv]
`timescale 1ns / 1ps
package kf2_pkg;
	localparam int DW = 32;
	localparam int FB = 24;
	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FB);
	localparam logic signed [DW-1:0] MILLI = DW'(((64'sd1 <<< FB) + 500) / 1000);

	typedef enum logic [2:0] {
		REG_APP = 3'd0,
		REG_APV = 3'd1,
		REG_AVP = 3'd2,
		REG_AVV = 3'd3,
		REG_BP  = 3'd4,
		REG_BV  = 3'd5
	} reg_idx_t;

	// register file slots of the datapath
	typedef enum logic [4:0] {
		R_XP, R_XV, R_PP, R_PV, R_VV,
		R_A11, R_A12, R_A21, R_A22, R_BP, R_BV,
		R_U, R_Q, R_Y, R_R,
		R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7, R_T8, R_T9,
		R_K1, R_K2, R_E, R_S, R_ACC, R_ZERO
	} slot_t;

	typedef enum logic [2:0] {
		OP_NOP, OP_MUL, OP_ADD, OP_SUB, OP_AVG, OP_DIV
	} op_t;

	typedef struct packed {
		op_t   op;
		slot_t sa;
		slot_t sb;
		slot_t dst;
	} uop_t;

	typedef struct packed {
		logic   load;
		logic   issue;
		uop_t   uop;
		logic   commit;
		logic   clr_clip;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic s_pos;
		logic has;
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_ISSUE, ST_WAIT, ST_CHECK, ST_DONE
	} state_t;

	function automatic uop_t prog(input logic [5:0] pc);
		uop_t u;
		u = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO};
		unique case (pc)
			6'd0:  u = '{OP_MUL, R_A11, R_XP, R_T0};
			6'd1:  u = '{OP_MUL, R_A12, R_XV, R_T1};
			6'd2:  u = '{OP_ADD, R_T0, R_T1, R_T0};
			6'd3:  u = '{OP_MUL, R_BP, R_U, R_T1};
			6'd4:  u = '{OP_ADD, R_T0, R_T1, R_T8};
			6'd5:  u = '{OP_MUL, R_A21, R_XP, R_T0};
			6'd6:  u = '{OP_MUL, R_A22, R_XV, R_T1};
			6'd7:  u = '{OP_ADD, R_T0, R_T1, R_T0};
			6'd8:  u = '{OP_MUL, R_BV, R_U, R_T1};
			6'd9:  u = '{OP_ADD, R_T0, R_T1, R_T9};
			6'd10: u = '{OP_MUL, R_A11, R_PP, R_T0};
			6'd11: u = '{OP_MUL, R_A12, R_PV, R_T1};
			6'd12: u = '{OP_ADD, R_T0, R_T1, R_T2};
			6'd13: u = '{OP_MUL, R_A11, R_PV, R_T0};
			6'd14: u = '{OP_MUL, R_A12, R_VV, R_T1};
			6'd15: u = '{OP_ADD, R_T0, R_T1, R_T3};
			6'd16: u = '{OP_MUL, R_A21, R_PP, R_T0};
			6'd17: u = '{OP_MUL, R_A22, R_PV, R_T1};
			6'd18: u = '{OP_ADD, R_T0, R_T1, R_T4};
			6'd19: u = '{OP_MUL, R_A21, R_PV, R_T0};
			6'd20: u = '{OP_MUL, R_A22, R_VV, R_T1};
			6'd21: u = '{OP_ADD, R_T0, R_T1, R_T5};
			6'd22: u = '{OP_MUL, R_BP, R_Q, R_T6};
			6'd23: u = '{OP_MUL, R_BV, R_Q, R_T7};
			6'd24: u = '{OP_MUL, R_T2, R_A11, R_T0};
			6'd25: u = '{OP_MUL, R_T3, R_A12, R_T1};
			6'd26: u = '{OP_ADD, R_T0, R_T1, R_T0};
			6'd27: u = '{OP_MUL, R_T6, R_BP, R_T1};
			6'd28: u = '{OP_ADD, R_T0, R_T1, R_PP};
			6'd29: u = '{OP_MUL, R_T6, R_BV, R_ACC};
			6'd30: u = '{OP_MUL, R_T2, R_A21, R_T0};
			6'd31: u = '{OP_MUL, R_T3, R_A22, R_T1};
			6'd32: u = '{OP_ADD, R_T0, R_T1, R_T0};
			6'd33: u = '{OP_ADD, R_T0, R_ACC, R_T0};
			6'd34: u = '{OP_MUL, R_T4, R_A11, R_T1};
			6'd35: u = '{OP_MUL, R_T5, R_A12, R_T2};
			6'd36: u = '{OP_ADD, R_T1, R_T2, R_T1};
			6'd37: u = '{OP_ADD, R_T1, R_ACC, R_T1};
			6'd38: u = '{OP_AVG, R_T0, R_T1, R_PV};
			6'd39: u = '{OP_MUL, R_T4, R_A21, R_T0};
			6'd40: u = '{OP_MUL, R_T5, R_A22, R_T1};
			6'd41: u = '{OP_ADD, R_T0, R_T1, R_T0};
			6'd42: u = '{OP_MUL, R_T7, R_BV, R_T1};
			6'd43: u = '{OP_ADD, R_T0, R_T1, R_VV};
			6'd44: u = '{OP_ADD, R_PP, R_R, R_S};
			6'd45: u = '{OP_DIV, R_PP, R_S, R_K1};
			6'd46: u = '{OP_DIV, R_PV, R_S, R_K2};
			6'd47: u = '{OP_SUB, R_Y, R_T8, R_E};
			6'd48: u = '{OP_MUL, R_K1, R_E, R_T0};
			6'd49: u = '{OP_ADD, R_T8, R_T0, R_T8};
			6'd50: u = '{OP_MUL, R_K2, R_E, R_T0};
			6'd51: u = '{OP_ADD, R_T9, R_T0, R_T9};
			6'd52: u = '{OP_MUL, R_K1, R_PP, R_T0};
			6'd53: u = '{OP_SUB, R_PP, R_T0, R_T0};
			6'd54: u = '{OP_MUL, R_K1, R_PV, R_T1};
			6'd55: u = '{OP_SUB, R_PV, R_T1, R_T1};
			6'd56: u = '{OP_MUL, R_K2, R_PP, R_T2};
			6'd57: u = '{OP_SUB, R_PV, R_T2, R_T2};
			6'd58: u = '{OP_MUL, R_K2, R_PV, R_T3};
			6'd59: u = '{OP_SUB, R_VV, R_T3, R_VV};
			6'd60: u = '{OP_ADD, R_T0, R_ZERO, R_PP};
			6'd61: u = '{OP_AVG, R_T1, R_T2, R_PV};
			default: u = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO};
		endcase
		return u;
	endfunction

	localparam logic [5:0] PC_PRED_END = 6'd43;
	localparam logic [5:0] PC_S = 6'd44;
	localparam logic [5:0] PC_LAST = 6'd61;
endpackage

[rtl/kalman_filter_two_state_top.sv]
`timescale 1ns / 1ps
// channel | handshake           | payload
// input   | in_valid/in_stall   | control_value, control_variance, has_position,
//         |                     | position_meas, position_variance
// output  | out_valid/out_stall | estimates, covariance, corrected, saturated
// Without a measurement a result is loaded when the prediction steps are done and the
// output register is free; the input is free in the cycle after, one item at a time.
// A measurement adds the update with two divides, skipped after a check when the
// innovation variance is not positive. One multiply/add unit and a 56-step restoring
// divider serve all steps. Reset clears state to zero estimates and 0.001 variances.
// A result waits in the output register while the next item is taken.
module kalman_filter_two_state_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] control_value,
	input  logic [30:0]        control_variance,
	input  logic               has_position,
	input  logic signed [31:0] position_meas,
	input  logic [30:0]        position_variance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] position_estimate,
	output logic signed [31:0] velocity_estimate,
	output logic signed [31:0] var_position,
	output logic signed [31:0] cov_pos_vel,
	output logic signed [31:0] var_velocity,
	output logic               corrected,
	output logic               saturated
);
	kf2_pkg::cmd_t cmd;
	kf2_pkg::sts_t sts;
	logic in_ready, res_load, corr_set, o_clip;
	logic signed [31:0] o_xp, o_xv, o_pp, o_pv, o_vv;
	logic out_busy;

	assign in_stall = !in_ready;
	assign out_busy = out_valid && out_stall;

	kf2_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_valid && in_ready), .out_busy(out_busy),
		.sts(sts), .in_ready(in_ready), .res_load(res_load), .corr_set(corr_set),
		.cmd(cmd)
	);

	kf2_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_data(cfg_data), .in_u(control_value), .in_q(control_variance),
		.in_has(has_position), .in_y(position_meas), .in_r(position_variance),
		.cmd(cmd), .sts(sts), .o_xp(o_xp), .o_xv(o_xv), .o_pp(o_pp), .o_pv(o_pv),
		.o_vv(o_vv), .o_clip(o_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			position_estimate <= o_xp;
			velocity_estimate <= o_xv;
			var_position <= o_pp;
			cov_pos_vel <= o_pv;
			var_velocity <= o_vv;
			corrected <= corr_set;
			saturated <= o_clip;
		end
	end
endmodule

[rtl/kf2_ctrl.sv]
`timescale 1ns / 1ps
module kf2_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_go,
	input  logic           out_busy,
	input  kf2_pkg::sts_t  sts,
	output logic           in_ready,
	output logic           res_load,
	output logic           corr_set,
	output kf2_pkg::cmd_t  cmd
);
	kf2_pkg::state_t state_q, state_d;
	logic [5:0] pc_q, pc_d;
	logic corr_q, corr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kf2_pkg::ST_IDLE;
			pc_q <= '0;
			corr_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			corr_q <= corr_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		corr_d = corr_q;
		in_ready = 1'b0;
		res_load = 1'b0;
		cmd = '0;
		cmd.uop = kf2_pkg::prog(pc_q);
		unique case (state_q)
			kf2_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_go) begin
					cmd.load = 1'b1;
					cmd.clr_clip = 1'b1;
					pc_d = '0;
					corr_d = 1'b0;
					state_d = kf2_pkg::ST_ISSUE;
				end
			end
			kf2_pkg::ST_LOAD: state_d = kf2_pkg::ST_ISSUE;
			kf2_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
				state_d = kf2_pkg::ST_WAIT;
			end
			kf2_pkg::ST_WAIT: begin
				if (!sts.busy) begin
					if (pc_q == kf2_pkg::PC_PRED_END && !sts.has) state_d = kf2_pkg::ST_DONE;
					else if (pc_q == kf2_pkg::PC_S) state_d = kf2_pkg::ST_CHECK;
					else if (pc_q == kf2_pkg::PC_LAST) state_d = kf2_pkg::ST_DONE;
					else begin
						pc_d = pc_q + 6'd1;
						state_d = kf2_pkg::ST_ISSUE;
					end
				end
			end
			kf2_pkg::ST_CHECK: begin
				if (sts.s_pos) begin
					corr_d = 1'b1;
					pc_d = pc_q + 6'd1;
					state_d = kf2_pkg::ST_ISSUE;
				end else state_d = kf2_pkg::ST_DONE;
			end
			kf2_pkg::ST_DONE: begin
				if (!out_busy) begin
					res_load = 1'b1;
					cmd.commit = 1'b1;
					state_d = kf2_pkg::ST_IDLE;
				end
			end
			default: state_d = kf2_pkg::ST_IDLE;
		endcase
	end
	assign corr_set = corr_q;
endmodule

[rtl/kf2_dp.sv]
`timescale 1ns / 1ps
module kf2_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic signed [31:0]    cfg_data,
	input  logic signed [31:0]    in_u,
	input  logic [30:0]           in_q,
	input  logic                  in_has,
	input  logic signed [31:0]    in_y,
	input  logic [30:0]           in_r,
	input  kf2_pkg::cmd_t         cmd,
	output kf2_pkg::sts_t         sts,
	output logic signed [31:0]    o_xp,
	output logic signed [31:0]    o_xv,
	output logic signed [31:0]    o_pp,
	output logic signed [31:0]    o_pv,
	output logic signed [31:0]    o_vv,
	output logic                  o_clip
);
	localparam int DW = kf2_pkg::DW;
	localparam int FB = kf2_pkg::FB;
	localparam int NUMW = DW + FB;

	logic signed [DW-1:0] rf_q [32];
	logic has_q, clip_q;

	logic signed [DW-1:0] opa, opb;
	assign opa = rf_q[cmd.uop.sa];
	assign opb = rf_q[cmd.uop.sb];

	// multiplier result stage
	logic mul_v_s1, res_v_q;
	logic signed [2*DW-1:0] prod_s1;
	logic signed [DW-1:0] res_q;
	logic res_clip_q;
	kf2_pkg::slot_t dst_q;

	// divider
	logic div_act_q, div_neg_q;
	logic [$clog2(NUMW+1)-1:0] div_cnt_q;
	logic [NUMW-1:0] num_q;
	logic [DW:0] rem_q;
	logic [NUMW-1:0] quo_q;
	logic [DW-1:0] den_q;

	logic signed [DW:0] sum_w;
	logic signed [DW-1:0] sum_sat;
	logic sum_clip;
	logic signed [DW-1:0] avg_w;
	logic signed [2*DW:0] rnd_w;
	logic signed [2*DW-FB:0] shr_w;
	logic signed [DW-1:0] mul_sat;
	logic mul_clip;
	logic [DW:0] rem_sh;
	logic [DW-1:0] mag_a;

	always_comb begin
		unique case (cmd.uop.op)
			kf2_pkg::OP_SUB: sum_w = {opa[DW-1], opa} - {opb[DW-1], opb};
			default: sum_w = {opa[DW-1], opa} + {opb[DW-1], opb};
		endcase
		sum_clip = sum_w[DW] != sum_w[DW-1];
		sum_sat = sum_clip ? (sum_w[DW] ? kf2_pkg::MINV : kf2_pkg::MAXV) : sum_w[DW-1:0];
		avg_w = sum_w[DW:1];
		mag_a = opa[DW-1] ? DW'(-opa) : opa;
		rnd_w = {prod_s1[2*DW-1], prod_s1} + (65'sd1 <<< (FB - 1));
		shr_w = rnd_w[2*DW:FB];
		mul_clip = shr_w > $signed({{(DW-FB+1){1'b0}}, kf2_pkg::MAXV})
			|| shr_w < $signed({{(DW-FB+1){1'b1}}, kf2_pkg::MINV});
		mul_sat = mul_clip ? (shr_w[2*DW-FB] ? kf2_pkg::MINV : kf2_pkg::MAXV)
			: shr_w[DW-1:0];
		rem_sh = {rem_q[DW-1:0], num_q[NUMW-1]};
	end

	logic [NUMW-1:0] quo_n;
	logic quo_clip;
	assign quo_n = {quo_q[NUMW-2:0], (rem_sh >= {1'b0, den_q})};
	// a negative quotient may reach the most negative value
	assign quo_clip = |quo_q[NUMW-1:DW]
		|| (quo_q[DW-1] && (!div_neg_q || |quo_q[DW-2:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1 <= 1'b0;
			res_v_q <= 1'b0;
			div_act_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			mul_v_s1 <= cmd.issue && cmd.uop.op == kf2_pkg::OP_MUL;
			res_v_q <= mul_v_s1 || (cmd.issue && (cmd.uop.op == kf2_pkg::OP_ADD
				|| cmd.uop.op == kf2_pkg::OP_SUB || cmd.uop.op == kf2_pkg::OP_AVG))
				|| (div_act_q && div_cnt_q == '0);
			if (cmd.issue && cmd.uop.op == kf2_pkg::OP_DIV) begin
				div_act_q <= 1'b1;
				div_cnt_q <= ($clog2(NUMW+1))'(NUMW);
			end else if (div_act_q) begin
				if (div_cnt_q == '0) div_act_q <= 1'b0;
				else div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			dst_q <= cmd.uop.dst;
			prod_s1 <= opa * opb;
		end
		unique case (1'b1)
			mul_v_s1: begin
				res_q <= mul_sat;
				res_clip_q <= mul_clip;
			end
			cmd.issue && cmd.uop.op == kf2_pkg::OP_AVG: begin
				res_q <= avg_w;
				res_clip_q <= 1'b0;
			end
			cmd.issue && (cmd.uop.op == kf2_pkg::OP_ADD || cmd.uop.op == kf2_pkg::OP_SUB): begin
				res_q <= sum_sat;
				res_clip_q <= sum_clip;
			end
			div_act_q && div_cnt_q == '0: begin
				res_q <= quo_clip ? (div_neg_q ? kf2_pkg::MINV : kf2_pkg::MAXV)
					: (div_neg_q ? -$signed(quo_q[DW-1:0]) : $signed(quo_q[DW-1:0]));
				res_clip_q <= quo_clip;
			end
			default: res_clip_q <= 1'b0;
		endcase
		if (cmd.issue && cmd.uop.op == kf2_pkg::OP_DIV) begin
			num_q <= {mag_a, {FB{1'b0}}};
			den_q <= opb;
			rem_q <= '0;
			quo_q <= '0;
			div_neg_q <= opa[DW-1];
		end else if (div_act_q && div_cnt_q != '0) begin
			num_q <= {num_q[NUMW-2:0], 1'b0};
			rem_q <= (rem_sh >= {1'b0, den_q}) ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= quo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q[kf2_pkg::R_XP] <= '0;
			rf_q[kf2_pkg::R_XV] <= '0;
			rf_q[kf2_pkg::R_PP] <= kf2_pkg::MILLI;
			rf_q[kf2_pkg::R_PV] <= '0;
			rf_q[kf2_pkg::R_VV] <= kf2_pkg::MILLI;
			rf_q[kf2_pkg::R_A11] <= kf2_pkg::ONE;
			rf_q[kf2_pkg::R_A12] <= '0;
			rf_q[kf2_pkg::R_A21] <= '0;
			rf_q[kf2_pkg::R_A22] <= kf2_pkg::ONE;
			rf_q[kf2_pkg::R_BP] <= '0;
			rf_q[kf2_pkg::R_BV] <= '0;
			rf_q[kf2_pkg::R_ZERO] <= '0;
			has_q <= 1'b0;
			clip_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					kf2_pkg::REG_APP: rf_q[kf2_pkg::R_A11] <= cfg_data;
					kf2_pkg::REG_APV: rf_q[kf2_pkg::R_A12] <= cfg_data;
					kf2_pkg::REG_AVP: rf_q[kf2_pkg::R_A21] <= cfg_data;
					kf2_pkg::REG_AVV: rf_q[kf2_pkg::R_A22] <= cfg_data;
					kf2_pkg::REG_BP:  rf_q[kf2_pkg::R_BP] <= cfg_data;
					kf2_pkg::REG_BV:  rf_q[kf2_pkg::R_BV] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				rf_q[kf2_pkg::R_U] <= in_u;
				rf_q[kf2_pkg::R_Q] <= {1'b0, in_q};
				rf_q[kf2_pkg::R_Y] <= in_y;
				rf_q[kf2_pkg::R_R] <= {1'b0, in_r};
				has_q <= in_has;
			end
			if (cmd.clr_clip) clip_q <= 1'b0;
			else if (res_v_q && res_clip_q) clip_q <= 1'b1;
			if (res_v_q && dst_q != kf2_pkg::R_ZERO) rf_q[dst_q] <= res_q;
			if (cmd.commit) begin
				rf_q[kf2_pkg::R_XP] <= rf_q[kf2_pkg::R_T8];
				rf_q[kf2_pkg::R_XV] <= rf_q[kf2_pkg::R_T9];
			end
		end
	end

	assign sts = '{
		busy: mul_v_s1 || res_v_q || div_act_q,
		s_pos: !rf_q[kf2_pkg::R_S][DW-1] && |rf_q[kf2_pkg::R_S],
		has: has_q
	};
	assign o_xp = rf_q[kf2_pkg::R_T8];
	assign o_xv = rf_q[kf2_pkg::R_T9];
	assign o_pp = rf_q[kf2_pkg::R_PP];
	assign o_pv = rf_q[kf2_pkg::R_PV];
	assign o_vv = rf_q[kf2_pkg::R_VV];
	assign o_clip = clip_q;
endmodule

[rtl/kf2_checker.sv]
`timescale 1ns / 1ps
module kf2_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic corrected,
	input logic has_position
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second item taken");
	a_reset_out: assert property (@(posedge clk)
		!arst_n |-> !out_valid) else $error("valid in reset");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(corrected)) else $error("stalled result changed");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(has_position))
		else $error("stalled transaction changed");
endmodule

bind kalman_filter_two_state_top kf2_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .corrected(corrected),
	.has_position(has_position)
);
